[design/array_list_insert_delete_engine_defines.svh]
// assertion macros for the array list engine
// no dependencies; included by the top level only
`ifndef ARRAY_LIST_INSERT_DELETE_ENGINE_DEFINES_SVH
`define ARRAY_LIST_INSERT_DELETE_ENGINE_DEFINES_SVH

// condition implies consequence in the same cycle
`define ALR_ASSERT_SAME(label, clk_s, rstn_s, cond, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define ALR_ASSERT_NEXT(label, clk_s, rstn_s, cond, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond) |=> (cons)) \
        else $error(msg);

`endif

[design/alr_pkg.sv]
// shared types, codes and sizes for the array list engine
// no dependencies; used by every module of the block
`default_nettype none

package alr_pkg;

    // list geometry
    localparam int CAPACITY   = 1024;
    localparam int DATA_W     = 32;
    localparam int GROUP_W    = 5;
    localparam int GROUP_SIZE = 1 << GROUP_W;
    localparam int N_GROUPS   = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GRP_IDX_W  = (N_GROUPS > 1) ? $clog2(N_GROUPS) : 1;
    localparam int COUNT_W    = $clog2(CAPACITY + 1);

    // field widths fixed by the interface
    localparam int MODE_W   = 3;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 3;
    localparam int LENGTH_W = 11;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH_HEAD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_TAIL = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_AFTER = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_HEAD  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_POP_TAIL  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DEL_AFTER = 3'd5;
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd6;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOKEY = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 3'd4;

    // request item
    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] key;
        logic [INDEX_W-1:0]       index;
    } alr_req_t;

    // response item
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [LENGTH_W-1:0]      length;
        logic signed [DATA_W-1:0] read_data;
    } alr_rsp_t;

    // where the shift boundary comes from
    typedef enum logic [1:0] {
        SHIFT_NONE = 2'd0,
        SHIFT_ALL  = 2'd1,
        SHIFT_TAIL = 2'd2,
        SHIFT_KEY  = 2'd3
    } shift_src_t;

    // per-cell load selection
    typedef struct packed {
        logic load_value;
        logic load_left;
        logic load_right;
    } cell_act_t;

    // control from the sequencer to every group
    typedef struct packed {
        logic       capture_hit;
        logic       capture_scan;
        logic       commit;
        logic       remove;
        shift_src_t shift_src;
    } alr_grp_ctrl_t;

    // search summary from a group
    typedef struct packed {
        logic any;
        logic early;
    } alr_grp_stat_t;

endpackage

`default_nettype wire

[design/array_list_insert_delete_engine.sv]
// array list engine top level: sequencer, group chain and result register
// depends on alr_pkg, alr_group, alr_cell and the defines header
//
//  channel | direction | handshake            | item
//  req     | in        | req_valid/req_ready  | alr_req_t: mode, value, key, index
//  rsp     | out       | rsp_valid/rsp_ready  | alr_rsp_t: status, length, read_data
//
// push/pop at either end go from idle to the apply stage; read passes the match
// capture stage first, insert/delete after key the match capture and group scan
// stages. every cell shifts in the same cycle, so list length adds no stages.
// reset clears the length but not the entries; entries beyond it are never read.
// a finished item waits in the result register; the next item is taken meanwhile
// and holds in its final stage until that register is free.
`default_nettype none
`include "array_list_insert_delete_engine_defines.svh"

module array_list_insert_delete_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  alr_pkg::alr_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output alr_pkg::alr_rsp_t rsp
);

    localparam int NG = alr_pkg::N_GROUPS;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_HIT   = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_APPLY = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    alr_pkg::alr_req_t               op_reg, op_next;
    logic [alr_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    alr_pkg::alr_rsp_t               rsp_reg, rsp_next;

    alr_pkg::alr_grp_ctrl_t          ctrl;
    logic signed [alr_pkg::DATA_W-1:0] grp_first [NG];
    logic signed [alr_pkg::DATA_W-1:0] grp_last  [NG];
    logic signed [alr_pkg::DATA_W-1:0] grp_rd    [NG];
    alr_pkg::alr_grp_stat_t          grp_stat  [NG];
    logic [NG-1:0]                   grp_bnd_last;
    logic [NG-1:0]                   grp_any;
    logic [NG-1:0]                   grp_early;
    logic [NG-1:0]                   grp_prior;

    logic                            req_fire;
    logic                            apply_fire;
    logic                            key_mode;
    logic                            found;
    logic                            early;
    logic                            full;
    logic                            in_range;
    logic [alr_pkg::GRP_IDX_W-1:0]   rd_sel;
    logic [alr_pkg::STATUS_W-1:0]    status;
    logic [alr_pkg::COUNT_W-1:0]     count_op;
    logic signed [alr_pkg::DATA_W-1:0] rd_val;

    assign req_ready  = (state_reg == ST_IDLE);
    assign req_fire   = req_valid && req_ready;
    assign apply_fire = (state_reg == ST_APPLY) && (!rsp_valid_reg || rsp_ready);
    assign key_mode   = (op_reg.mode == alr_pkg::MODE_INS_AFTER)
                     || (op_reg.mode == alr_pkg::MODE_DEL_AFTER);

    // group chain
    for (genvar g = 0; g < NG; g++)
    begin : g_grp
        logic signed [alr_pkg::DATA_W-1:0] left_w;
        logic signed [alr_pkg::DATA_W-1:0] right_w;
        logic                              bnd_w;

        if (g == 0)
        begin : g_first
            assign left_w = '0;
            assign bnd_w  = 1'b0;
        end
        else
        begin : g_mid_lo
            assign left_w = grp_last[g-1];
            assign bnd_w  = grp_bnd_last[g-1];
        end

        if (g == NG - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_hi
            assign right_w = grp_first[g+1];
        end

        assign grp_any[g]   = grp_stat[g].any;
        assign grp_early[g] = grp_stat[g].early;

        alr_group u_group (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .op          (op_reg),
            .count       (count_reg),
            .grp_base    (alr_pkg::COUNT_W'(g * alr_pkg::GROUP_SIZE)),
            .grp_prior   (grp_prior[g]),
            .left_in     (left_w),
            .right_in    (right_w),
            .bnd_in      (bnd_w),
            .first_entry (grp_first[g]),
            .last_entry  (grp_last[g]),
            .bnd_last    (grp_bnd_last[g]),
            .stat        (grp_stat[g]),
            .rd_data     (grp_rd[g])
        );
    end

    // match seen in any earlier group
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_prior[g] = |(grp_any & ~({NG{1'b1}} << g));
        end
    end

    assign found    = |grp_any;
    assign early    = |grp_early;
    assign full     = 32'(count_reg) >= alr_pkg::CAPACITY;
    assign in_range = (32'(op_reg.index) < 32'(count_reg))
                   && (32'(op_reg.index) < alr_pkg::CAPACITY);
    assign rd_sel   = alr_pkg::GRP_IDX_W'(32'(op_reg.index) >> alr_pkg::GROUP_W);

    // operation decode: status, new length, shift kind and group control
    always_comb
    begin
        status            = alr_pkg::STATUS_OK;
        count_op          = count_reg;
        rd_val            = '0;
        ctrl.capture_hit  = (state_reg == ST_HIT);
        ctrl.capture_scan = (state_reg == ST_SCAN);
        ctrl.remove       = 1'b0;
        ctrl.shift_src    = alr_pkg::SHIFT_NONE;
        case (op_reg.mode)
            alr_pkg::MODE_PUSH_HEAD:
            begin
                ctrl.shift_src = alr_pkg::SHIFT_ALL;
                if (full)
                begin
                    status = alr_pkg::STATUS_FULL;
                end
                else
                begin
                    count_op = count_reg + alr_pkg::COUNT_W'(1);
                end
            end
            alr_pkg::MODE_PUSH_TAIL:
            begin
                ctrl.shift_src = alr_pkg::SHIFT_TAIL;
                if (full)
                begin
                    status = alr_pkg::STATUS_FULL;
                end
                else
                begin
                    count_op = count_reg + alr_pkg::COUNT_W'(1);
                end
            end
            alr_pkg::MODE_INS_AFTER:
            begin
                ctrl.shift_src = alr_pkg::SHIFT_KEY;
                if (full)
                begin
                    status = alr_pkg::STATUS_FULL;
                end
                else if (!found)
                begin
                    status = alr_pkg::STATUS_NOKEY;
                end
                else
                begin
                    count_op = count_reg + alr_pkg::COUNT_W'(1);
                end
            end
            alr_pkg::MODE_POP_HEAD:
            begin
                ctrl.shift_src = alr_pkg::SHIFT_ALL;
                ctrl.remove    = 1'b1;
                if (count_reg == '0)
                begin
                    status = alr_pkg::STATUS_EMPTY;
                end
                else
                begin
                    count_op = count_reg - alr_pkg::COUNT_W'(1);
                end
            end
            alr_pkg::MODE_POP_TAIL:
            begin
                if (count_reg == '0)
                begin
                    status = alr_pkg::STATUS_EMPTY;
                end
                else
                begin
                    count_op = count_reg - alr_pkg::COUNT_W'(1);
                end
            end
            alr_pkg::MODE_DEL_AFTER:
            begin
                ctrl.shift_src = alr_pkg::SHIFT_KEY;
                ctrl.remove    = 1'b1;
                if (count_reg == '0)
                begin
                    status = alr_pkg::STATUS_EMPTY;
                end
                else if (!found)
                begin
                    status = alr_pkg::STATUS_NOKEY;
                end
                else if (!early)
                begin
                    status = alr_pkg::STATUS_EMPTY;
                end
                else
                begin
                    count_op = count_reg - alr_pkg::COUNT_W'(1);
                end
            end
            alr_pkg::MODE_READ:
            begin
                if (!in_range)
                begin
                    status = alr_pkg::STATUS_RANGE;
                end
                else
                begin
                    rd_val = grp_rd[rd_sel];
                end
            end
            default:
            begin
                status = alr_pkg::STATUS_OK;
            end
        endcase
        // cells move only for a successful operation
        ctrl.commit = apply_fire && (status == alr_pkg::STATUS_OK);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if ((req.mode == alr_pkg::MODE_INS_AFTER)
                        || (req.mode == alr_pkg::MODE_DEL_AFTER)
                        || (req.mode == alr_pkg::MODE_READ))
                    begin
                        state_next = ST_HIT;
                    end
                    else
                    begin
                        state_next = ST_APPLY;
                    end
                end
            end
            ST_HIT:
            begin
                state_next = key_mode ? ST_SCAN : ST_APPLY;
            end
            ST_SCAN:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (apply_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // operation latch
    assign op_next = req_fire ? req : op_reg;

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

    // length and result register
    always_comb
    begin
        count_next     = count_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (apply_fire)
        begin
            count_next         = count_op;
            rsp_next.status    = status;
            rsp_next.length    = alr_pkg::LENGTH_W'(count_op);
            rsp_next.read_data = rd_val;
            rsp_valid_next     = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    `ALR_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, 32'(count_reg) <= alr_pkg::CAPACITY, "length above capacity")
    `ALR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_fire, state_reg != ST_IDLE, "idle right after accepting an item")
    `ALR_ASSERT_NEXT(a_count_only_on_apply, clk, rst_n, !apply_fire, $stable(count_reg), "length moved outside the apply stage")
    `ALR_ASSERT_NEXT(a_result_posted, clk, rst_n, apply_fire, rsp_valid_reg, "finished item not posted")

endmodule

`default_nettype wire

[design/alr_cell.sv]
// one list cell: holds an entry and its key match flag
// depends on alr_pkg
`default_nettype none

module alr_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  alr_pkg::cell_act_t                act,
    input  logic                              capture_hit,
    input  logic                              in_list,
    input  logic signed [alr_pkg::DATA_W-1:0] key,
    input  logic signed [alr_pkg::DATA_W-1:0] value,
    input  logic signed [alr_pkg::DATA_W-1:0] left_data,
    input  logic signed [alr_pkg::DATA_W-1:0] right_data,
    output logic signed [alr_pkg::DATA_W-1:0] entry,
    output logic                              hit
);

    logic signed [alr_pkg::DATA_W-1:0] entry_reg, entry_next;
    logic                              hit_reg, hit_next;

    // entry load: new value, left neighbour or right neighbour
    always_comb
    begin
        entry_next = entry_reg;
        if (act.load_value)
        begin
            entry_next = value;
        end
        else if (act.load_left)
        begin
            entry_next = left_data;
        end
        else if (act.load_right)
        begin
            entry_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // key compare, only live entries count
    always_comb
    begin
        hit_next = hit_reg;
        if (capture_hit)
        begin
            hit_next = (entry_reg == key) && in_list;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

`default_nettype wire

[design/alr_group.sv]
// group of list cells with local match prefix, search summary and read pick
// depends on alr_pkg and alr_cell
`default_nettype none

module alr_group (
    input  logic                               clk,
    input  logic                               rst_n,
    input  alr_pkg::alr_grp_ctrl_t             ctrl,
    input  alr_pkg::alr_req_t                  op,
    input  logic [alr_pkg::COUNT_W-1:0]        count,
    input  logic [alr_pkg::COUNT_W-1:0]        grp_base,
    input  logic                               grp_prior,
    input  logic signed [alr_pkg::DATA_W-1:0]  left_in,
    input  logic signed [alr_pkg::DATA_W-1:0]  right_in,
    input  logic                               bnd_in,
    output logic signed [alr_pkg::DATA_W-1:0]  first_entry,
    output logic signed [alr_pkg::DATA_W-1:0]  last_entry,
    output logic                               bnd_last,
    output alr_pkg::alr_grp_stat_t             stat,
    output logic signed [alr_pkg::DATA_W-1:0]  rd_data
);

    localparam int GS = alr_pkg::GROUP_SIZE;

    logic signed [alr_pkg::DATA_W-1:0] entry_w [GS];
    alr_pkg::cell_act_t                act_w [GS];
    logic [GS-1:0]                     hit_w;
    logic [GS-1:0]                     in_list_w;
    logic [GS-1:0]                     before_last_w;
    logic [GS-1:0]                     bnd_w;
    logic [GS-1:0]                     bnd_prev_w;

    logic [GS-1:0]                     lp_reg, lp_next;
    logic                              any_reg, any_next;
    logic                              early_reg, early_next;
    logic signed [alr_pkg::DATA_W-1:0] rd_reg, rd_next;

    // position flags and shift boundary per cell
    always_comb
    begin
        int unsigned pos;
        for (int k = 0; k < GS; k++)
        begin
            pos              = 32'(grp_base) + 32'(k);
            in_list_w[k]     = pos < 32'(count);
            before_last_w[k] = (pos + 32'd1) < 32'(count);
            case (ctrl.shift_src)
                alr_pkg::SHIFT_ALL:  bnd_w[k] = 1'b1;
                alr_pkg::SHIFT_TAIL: bnd_w[k] = pos >= 32'(count);
                alr_pkg::SHIFT_KEY:  bnd_w[k] = lp_reg[k] | grp_prior;
                default:             bnd_w[k] = 1'b0;
            endcase
        end
    end

    // boundary of the cell below, chained across groups
    always_comb
    begin
        bnd_prev_w[0] = bnd_in;
        for (int k = 1; k < GS; k++)
        begin
            bnd_prev_w[k] = bnd_w[k-1];
        end
    end

    // load selection: insert opens a gap at the boundary, delete closes it
    always_comb
    begin
        for (int k = 0; k < GS; k++)
        begin
            act_w[k].load_value = ctrl.commit && !ctrl.remove && bnd_w[k] && !bnd_prev_w[k];
            act_w[k].load_left  = ctrl.commit && !ctrl.remove && bnd_prev_w[k];
            act_w[k].load_right = ctrl.commit && ctrl.remove && bnd_w[k];
        end
    end

    // the cells, each wired to its neighbours
    for (genvar k = 0; k < GS; k++)
    begin : g_cell
        logic signed [alr_pkg::DATA_W-1:0] left_w;
        logic signed [alr_pkg::DATA_W-1:0] right_w;

        if (k == 0)
        begin : g_lo
            assign left_w = left_in;
        end
        else
        begin : g_lo_in
            assign left_w = entry_w[k-1];
        end

        if (k == GS - 1)
        begin : g_hi
            assign right_w = right_in;
        end
        else
        begin : g_hi_in
            assign right_w = entry_w[k+1];
        end

        alr_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .act         (act_w[k]),
            .capture_hit (ctrl.capture_hit),
            .in_list     (in_list_w[k]),
            .key         (op.key),
            .value       (op.value),
            .left_data   (left_w),
            .right_data  (right_w),
            .entry       (entry_w[k]),
            .hit         (hit_w[k])
        );
    end

    // local exclusive match prefix and group summary
    always_comb
    begin
        lp_next    = lp_reg;
        any_next   = any_reg;
        early_next = early_reg;
        if (ctrl.capture_scan)
        begin
            for (int k = 0; k < GS; k++)
            begin
                lp_next[k] = |(hit_w & ~({GS{1'b1}} << k));
            end
            any_next   = |hit_w;
            early_next = |(hit_w & before_last_w);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg    <= '0;
            any_reg   <= 1'b0;
            early_reg <= 1'b0;
        end
        else
        begin
            lp_reg    <= lp_next;
            any_reg   <= any_next;
            early_reg <= early_next;
        end
    end

    // read pick within the group
    always_comb
    begin
        rd_next = rd_reg;
        if (ctrl.capture_hit)
        begin
            rd_next = entry_w[op.index[alr_pkg::GROUP_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= rd_next;
    end

    assign first_entry = entry_w[0];
    assign last_entry  = entry_w[GS-1];
    assign bnd_last    = bnd_w[GS-1];
    assign stat        = {any_reg, early_reg};
    assign rd_data     = rd_reg;

endmodule

`default_nettype wire
